[sv/tmts_pkg.sv]
// shared types, field widths and codes for the tempo map tick to sample block
`default_nettype none

package tmts_pkg;

    localparam int KIND_W     = 2;
    localparam int TICK_W     = 32;
    localparam int TEMPO_W    = 24;
    localparam int POS_W      = 48;
    localparam int STATUS_W   = 2;
    localparam int RATE_W     = 18;
    localparam int DIV_W      = 15;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 18;

    localparam logic [KIND_W-1:0] KIND_CLEAR   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_ADD     = 2'd1;
    localparam logic [KIND_W-1:0] KIND_CONVERT = 2'd2;

    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_ORDER = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_RATE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_DIVISION    = 1'b1;

    localparam logic [TEMPO_W-1:0] DEFAULT_TEMPO = 24'd500000;
    localparam logic [19:0]        US_PER_SEC    = 20'd1000000;
    localparam logic [POS_W-1:0]   POS_MAX       = '1;
    localparam logic [RATE_W-1:0]  RESET_RATE    = 18'd44100;
    localparam logic [DIV_W-1:0]   RESET_DIV     = 15'd480;

    typedef struct packed {
        logic [TICK_W-1:0]  tick;
        logic [TEMPO_W-1:0] tempo;
        logic [POS_W-1:0]   offset;
    } seg_t;

    typedef struct packed {
        logic               start;
        logic [TICK_W-1:0]  delta;
        logic [TEMPO_W-1:0] tempo;
    } span_req_t;

    typedef struct packed {
        logic             done;
        logic [POS_W-1:0] span;
    } span_rsp_t;

    typedef enum logic [2:0] {
        CS_IDLE,
        CS_LAST_RD,
        CS_LAST_CHK,
        CS_SCAN,
        CS_SPAN_GO,
        CS_SPAN_WAIT,
        CS_FINISH
    } ctrl_state_t;

    typedef enum logic [2:0] {
        SP_IDLE,
        SP_MUL_LO,
        SP_MUL_HI,
        SP_SUM,
        SP_CHECK,
        SP_DIV,
        SP_DONE
    } span_state_t;

endpackage

`default_nettype wire

[sv/tmts_req_if.sv]
// input item channel: kind, tick and tempo
`default_nettype none

interface tmts_req_if import tmts_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [KIND_W-1:0]  kind;
    logic [TICK_W-1:0]  tick;
    logic [TEMPO_W-1:0] tempo_us;

    modport source (output valid, output kind, output tick, output tempo_us, input ready);
    modport sink   (input valid, input kind, input tick, input tempo_us, output ready);
endinterface

`default_nettype wire

[sv/tmts_rsp_if.sv]
// result item channel: sample position and status
`default_nettype none

interface tmts_rsp_if import tmts_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [POS_W-1:0]    sample_pos;
    logic [STATUS_W-1:0] status;

    modport source (output valid, output sample_pos, output status, input ready);
    modport sink   (input valid, input sample_pos, input status, output ready);
endinterface

`default_nettype wire

[sv/tmts_cfg_if.sv]
// configuration write channel: register index and data
`default_nettype none

interface tmts_cfg_if import tmts_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

[sv/tmts_ram.sv]
// generic single-write, single-read ram with registered read data
`default_nettype none

module tmts_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

[sv/tmts_span.sv]
// span length unit: delta*tempo*rate*2^frac / (1e6*division), saturated, bit-serial divide
`default_nettype none

module tmts_span import tmts_pkg::*; #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire span_req_t         req,
    input  wire logic [RATE_W-1:0] rate,
    input  wire logic [DIV_W-1:0]  division,
    output span_rsp_t              rsp
);

    localparam int P_W    = TICK_W + TEMPO_W;
    localparam int HALF_W = P_W / 2;
    localparam int PART_W = (P_W - HALF_W) + RATE_W;
    localparam int NUMB_W = P_W + RATE_W;
    localparam int NUM_W  = NUMB_W + FRAC_BITS;
    localparam int DEN_W  = 35;
    localparam int R_W    = DEN_W + 1;
    localparam int CMP_W  = (NUM_W > DEN_W + POS_W) ? NUM_W : DEN_W + POS_W;
    localparam int STEP_W = $clog2(POS_W);

    span_state_t       state_reg, state_next;
    logic [P_W-1:0]    p_reg;
    logic [PART_W-1:0] lo_reg;
    logic [PART_W-1:0] hi_reg;
    logic [DEN_W-1:0]  den_reg;
    logic [NUMB_W-1:0] num_reg;
    logic              sat_reg;
    logic [R_W-1:0]    r_reg;
    logic [POS_W-1:0]  nlo_reg;
    logic [POS_W-1:0]  q_reg;
    logic [STEP_W-1:0] step_reg;

    logic [DIV_W-1:0] div_eff;
    logic [CMP_W-1:0] num_ext;
    logic [CMP_W-1:0] den_ext;
    logic [R_W-1:0]   r_shift;
    logic             r_ge;
    logic             last_step;

    // zero division register counts as one
    assign div_eff   = (division == '0) ? DIV_W'(1) : division;
    assign num_ext   = CMP_W'(num_reg) << FRAC_BITS;
    assign den_ext   = CMP_W'(den_reg) << POS_W;
    assign r_shift   = {r_reg[R_W-2:0], nlo_reg[POS_W-1]};
    assign r_ge      = r_shift >= R_W'(den_reg);
    assign last_step = step_reg == STEP_W'(POS_W - 1);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            SP_IDLE:   if (req.start) state_next = SP_MUL_LO;
            SP_MUL_LO: state_next = SP_MUL_HI;
            SP_MUL_HI: state_next = SP_SUM;
            SP_SUM:    state_next = SP_CHECK;
            SP_CHECK:  state_next = SP_DIV;
            SP_DIV:    if (last_step) state_next = SP_DONE;
            SP_DONE:   state_next = SP_IDLE;
            default:   state_next = SP_IDLE;
        endcase
    end

    always_comb
    begin
        rsp.done = (state_reg == SP_DONE);
        rsp.span = sat_reg ? POS_MAX : q_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= SP_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            SP_IDLE:
            begin
                p_reg <= P_W'(req.delta) * P_W'(req.tempo);
            end
            SP_MUL_LO:
            begin
                lo_reg <= PART_W'(p_reg[HALF_W-1:0]) * PART_W'(rate);
            end
            SP_MUL_HI:
            begin
                hi_reg  <= PART_W'(p_reg[P_W-1:HALF_W]) * PART_W'(rate);
                den_reg <= DEN_W'(DEN_W'(US_PER_SEC) * DEN_W'(div_eff));
            end
            SP_SUM:
            begin
                num_reg <= NUMB_W'(lo_reg) + (NUMB_W'(hi_reg) << HALF_W);
            end
            SP_CHECK:
            begin
                // quotient of 2^48 or more saturates; else top bits are below den
                sat_reg  <= num_ext >= den_ext;
                r_reg    <= R_W'(num_ext >> POS_W);
                nlo_reg  <= num_ext[POS_W-1:0];
                q_reg    <= '0;
                step_reg <= '0;
            end
            SP_DIV:
            begin
                r_reg    <= r_ge ? (r_shift - R_W'(den_reg)) : r_shift;
                q_reg    <= {q_reg[POS_W-2:0], r_ge};
                nlo_reg  <= {nlo_reg[POS_W-2:0], 1'b0};
                step_reg <= step_reg + STEP_W'(1);
            end
            default:
            begin
            end
        endcase
    end

endmodule

`default_nettype wire

[sv/tempo_map_tick_to_sample_core.sv]
// top level: tempo map held in ram, segment scan and span unit
// flow: clear, unused kind or tick-zero add go straight to the result; a dropped add
//   reads and checks the last segment; an appended add also runs the span unit;
//   convert scans one map entry per cycle, then span unit setup and 48-step divide
// throughput: one item at a time; the next item is taken while a result waits
// reset: map holds one segment at tick 0 with tempo 500000, sample_rate 44100,
//   division 480; ram entries above the fill count are never read, no clearing pass
`default_nettype none

module tempo_map_tick_to_sample_core import tmts_pkg::*; #(
    parameter int MAP_DEPTH = 64,
    parameter int FRAC_BITS = 16
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    tmts_req_if.sink   req,
    tmts_rsp_if.source rsp,
    tmts_cfg_if.sink   cfg
);

    localparam int IDX_W = $clog2(MAP_DEPTH);
    localparam int CNT_W = $clog2(MAP_DEPTH + 1);

    // control state
    ctrl_state_t         state_reg, state_next;
    logic [CNT_W-1:0]    count_reg;
    logic [TEMPO_W-1:0]  tempo0_reg;
    logic [CNT_W-1:0]    idx_reg;
    logic                pend_reg;
    logic                out_valid_reg;
    logic [RATE_W-1:0]   rate_reg;
    logic [DIV_W-1:0]    div_reg;

    // item payload and working segment
    logic [KIND_W-1:0]   kind_reg;
    logic [TICK_W-1:0]   tick_reg;
    logic [TEMPO_W-1:0]  tempo_in_reg;
    seg_t                sel_reg;
    logic [POS_W-1:0]    res_pos_reg;
    logic [STATUS_W-1:0] res_status_reg;
    logic [POS_W-1:0]    out_pos_reg;
    logic [STATUS_W-1:0] out_status_reg;

    // ram port
    logic                ram_we;
    logic [IDX_W-1:0]    ram_waddr;
    logic [IDX_W-1:0]    ram_raddr;
    seg_t                ram_wdata;
    seg_t                rd_seg;
    logic [$bits(seg_t)-1:0] ram_rdata;

    span_req_t           span_req;
    span_rsp_t           span_rsp;

    seg_t                seg0;
    seg_t                last_seg;
    logic [CNT_W-1:0]    cnt_m1;
    logic                accept;
    logic                order_bad;
    logic                full;
    logic                scan_stop;
    logic                scan_done;
    logic                finish_load;
    logic [POS_W:0]      sum_wide;
    logic [POS_W-1:0]    sum_sat;

    // segment 0 always starts at tick 0 and sample 0; only its tempo is stored
    assign seg0      = {TICK_W'(0), tempo0_reg, POS_W'(0)};
    assign rd_seg    = seg_t'(ram_rdata);
    assign cnt_m1    = count_reg - CNT_W'(1);
    assign last_seg  = (count_reg == CNT_W'(1)) ? seg0 : rd_seg;
    assign order_bad = tick_reg < last_seg.tick;
    assign full      = count_reg >= CNT_W'(MAP_DEPTH);

    // scan: data for idx_reg-1 arrives while idx_reg is being read
    assign scan_stop = pend_reg && (rd_seg.tick > tick_reg);
    assign scan_done = scan_stop || (idx_reg == count_reg);

    assign accept      = req.valid && req.ready;
    assign finish_load = (state_reg == CS_FINISH) && (!out_valid_reg || rsp.ready);

    // segment offset plus span, saturating at 48 bits
    assign sum_wide = {1'b0, sel_reg.offset} + {1'b0, span_rsp.span};
    assign sum_sat  = sum_wide[POS_W] ? POS_MAX : sum_wide[POS_W-1:0];

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            CS_IDLE:
            begin
                if (req.valid)
                begin
                    case (req.kind)
                        KIND_ADD:     state_next = (req.tick == '0) ? CS_FINISH : CS_LAST_RD;
                        KIND_CONVERT: state_next = CS_SCAN;
                        default:      state_next = CS_FINISH;
                    endcase
                end
            end
            CS_LAST_RD:   state_next = CS_LAST_CHK;
            CS_LAST_CHK:  state_next = (order_bad || full) ? CS_FINISH : CS_SPAN_GO;
            CS_SCAN:      if (scan_done) state_next = CS_SPAN_GO;
            CS_SPAN_GO:   state_next = CS_SPAN_WAIT;
            CS_SPAN_WAIT: if (span_rsp.done) state_next = CS_FINISH;
            CS_FINISH:    if (!out_valid_reg || rsp.ready) state_next = CS_IDLE;
            default:      state_next = CS_IDLE;
        endcase
    end

    // state outputs
    always_comb
    begin
        req.ready      = (state_reg == CS_IDLE);
        ram_raddr      = '0;
        span_req.start = (state_reg == CS_SPAN_GO);
        span_req.delta = tick_reg - sel_reg.tick;
        span_req.tempo = sel_reg.tempo;
        ram_we         = (state_reg == CS_SPAN_WAIT) && span_rsp.done && (kind_reg == KIND_ADD);
        ram_waddr      = count_reg[IDX_W-1:0];
        ram_wdata      = {tick_reg, tempo_in_reg, sum_sat};
        unique case (state_reg)
            CS_LAST_RD: ram_raddr = cnt_m1[IDX_W-1:0];
            CS_SCAN:    ram_raddr = idx_reg[IDX_W-1:0];
            default:    ram_raddr = '0;
        endcase
    end

    assign rsp.valid      = out_valid_reg;
    assign rsp.sample_pos = out_pos_reg;
    assign rsp.status     = out_status_reg;
    assign cfg.ready      = 1'b1;

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= CS_IDLE;
            count_reg     <= CNT_W'(1);
            tempo0_reg    <= DEFAULT_TEMPO;
            idx_reg       <= CNT_W'(1);
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            rate_reg      <= RESET_RATE;
            div_reg       <= RESET_DIV;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg.valid && cfg.ready)
            begin
                unique case (cfg.index)
                    CFG_SAMPLE_RATE: rate_reg <= cfg.data;
                    CFG_DIVISION:    div_reg  <= cfg.data[DIV_W-1:0];
                    default:         rate_reg <= rate_reg;
                endcase
            end

            if (accept)
            begin
                case (req.kind)
                    KIND_CLEAR:
                    begin
                        count_reg  <= CNT_W'(1);
                        tempo0_reg <= DEFAULT_TEMPO;
                    end
                    KIND_ADD:
                    begin
                        // tempo at tick zero rewrites the first segment while it is alone
                        if ((req.tick == '0) && (count_reg == CNT_W'(1)))
                        begin
                            tempo0_reg <= req.tempo_us;
                        end
                    end
                    KIND_CONVERT:
                    begin
                        idx_reg  <= CNT_W'(1);
                        pend_reg <= 1'b0;
                    end
                    default:
                    begin
                    end
                endcase
            end

            if (state_reg == CS_SCAN)
            begin
                idx_reg  <= idx_reg + CNT_W'(1);
                pend_reg <= idx_reg < count_reg;
            end

            if (ram_we)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end

            if (finish_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            kind_reg       <= req.kind;
            tick_reg       <= req.tick;
            tempo_in_reg   <= req.tempo_us;
            res_pos_reg    <= '0;
            sel_reg        <= seg0;
            // tick zero once changes exist is out of order
            if ((req.kind == KIND_ADD) && (req.tick == '0) && (count_reg != CNT_W'(1)))
            begin
                res_status_reg <= STATUS_ORDER;
            end
            else
            begin
                res_status_reg <= STATUS_OK;
            end
        end

        if (state_reg == CS_LAST_CHK)
        begin
            sel_reg <= last_seg;
            // order is checked before fullness
            if (order_bad)
            begin
                res_status_reg <= STATUS_ORDER;
            end
            else if (full)
            begin
                res_status_reg <= STATUS_FULL;
            end
        end

        if ((state_reg == CS_SCAN) && pend_reg && !scan_stop)
        begin
            sel_reg <= rd_seg;
        end

        if ((state_reg == CS_SPAN_WAIT) && span_rsp.done && (kind_reg == KIND_CONVERT))
        begin
            res_pos_reg <= sum_sat;
        end

        if (finish_load)
        begin
            out_pos_reg    <= res_pos_reg;
            out_status_reg <= res_status_reg;
        end
    end

    tmts_ram #(
        .WIDTH ($bits(seg_t)),
        .DEPTH (MAP_DEPTH)
    ) u_map_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    tmts_span #(
        .FRAC_BITS (FRAC_BITS)
    ) u_span (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (span_req),
        .rate     (rate_reg),
        .division (div_reg),
        .rsp      (span_rsp)
    );

endmodule

`default_nettype wire

[verif/tempo_map_tick_to_sample_core_test.sv]
// self-checking bench for the tempo map core: scoreboard against a shadow tempo map
module tempo_map_tick_to_sample_core_test;
    import tmts_pkg::*;

    localparam int MAP_DEPTH   = 64;
    localparam int FRAC_BITS   = 16;
    localparam int CYCLE_LIMIT = 1500000;
    localparam int LONG_HOLD   = 400;
    localparam int SETTLE      = 150;
    localparam int PHASE_ITEMS = 125;

    // the kind code that the block must ignore
    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [TICK_W-1:0]  tick;
        logic [TEMPO_W-1:0] tempo_us;
    } tempo_event_t;

    typedef struct packed {
        logic [POS_W-1:0]    sample_pos;
        logic [STATUS_W-1:0] status;
    } position_t;

    logic clk = 1'b0;
    logic rst_n;

    tmts_req_if req_ch ();
    tmts_rsp_if rsp_ch ();
    tmts_cfg_if cfg_ch ();

    tempo_map_tick_to_sample_core #(
        .MAP_DEPTH (MAP_DEPTH),
        .FRAC_BITS (FRAC_BITS)
    ) u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch),
        .cfg   (cfg_ch)
    );

    always #5 clk = ~clk;

    // shadow tempo map and register copies used for prediction
    logic [TICK_W-1:0]  tm_tick   [MAP_DEPTH];
    logic [TEMPO_W-1:0] tm_tempo  [MAP_DEPTH];
    logic [POS_W-1:0]   tm_offset [MAP_DEPTH];
    int                 tm_segs;
    logic [RATE_W-1:0]  rate_cfg;
    logic [DIV_W-1:0]   div_cfg;

    // items waiting to be offered, and positions the block still owes us
    tempo_event_t tempo_events [$];
    position_t    due_positions [$];

    // generator's own guess of the map, used only to shape stimulus
    logic [TICK_W-1:0] gen_ticks [MAP_DEPTH];
    int                gen_segs;

    // run bookkeeping
    int mismatches     = 0;
    int accepted_items = 0;
    int checked_items  = 0;
    int cfg_writes     = 0;
    int status_tally [4];
    int cycle_count    = 0;

    // idling controls, changed only by nonblocking writes from the stimulus and the hold-off block
    bit quiet_mode  = 1'b0;
    bit eager_send  = 1'b0;
    int holds_asked = 0;
    int holds_done  = 0;
    int hold_left   = 0;

    // driver and monitor state
    bit           item_held = 1'b0;
    tempo_event_t held_ev;
    int           send_gap  = 0;
    int           stall_left = 0;
    position_t    predicted_pos;
    position_t    got_pos;
    position_t    want_pos;

    task automatic report_mismatch(input string what);
        mismatches++;
        if (mismatches <= 200)
            $display("MISMATCH at %0t: %s", $time, what);
    endtask

    // gap length: mostly none or short, now and then a long one
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 15);
        return $urandom_range(30, 80);
    endfunction

    // fixed-point samples spanned by delta ticks at one tempo, truncated, saturating
    function automatic logic [POS_W-1:0] tick_span(input logic [TICK_W-1:0] delta,
                                                   input logic [TEMPO_W-1:0] tempo);
        logic [127:0]     num;
        logic [127:0]     den;
        logic [127:0]     quo;
        logic [DIV_W-1:0] div_eff;
        // a zero division register acts as one
        div_eff = (div_cfg == '0) ? DIV_W'(1) : div_cfg;
        num = delta;
        num = num * tempo;
        num = num * rate_cfg;
        num = num << FRAC_BITS;
        den = US_PER_SEC;
        den = den * div_eff;
        quo = num / den;
        if (quo > POS_MAX)
            return POS_MAX;
        return quo[POS_W-1:0];
    endfunction

    function automatic logic [POS_W-1:0] pos_add_sat(input logic [POS_W-1:0] a,
                                                     input logic [POS_W-1:0] b);
        logic [POS_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[POS_W] ? POS_MAX : s[POS_W-1:0];
    endfunction

    // applies one accepted item to the shadow map and returns the position it yields
    task automatic map_apply(input tempo_event_t ev, output position_t res);
        int   last;
        int   sel;
        int   i;
        logic scanning;
        res.sample_pos = '0;
        res.status     = STATUS_OK;
        case (ev.kind)
            KIND_CLEAR: begin
                tm_segs      = 1;
                tm_tick[0]   = '0;
                tm_tempo[0]  = DEFAULT_TEMPO;
                tm_offset[0] = '0;
            end
            KIND_ADD: begin
                last = tm_segs - 1;
                if (ev.tick == '0) begin
                    // tick zero only rewrites the first tempo while no change is stored
                    if (tm_segs == 1)
                        tm_tempo[0] = ev.tempo_us;
                    else
                        res.status = STATUS_ORDER;
                end else if (ev.tick < tm_tick[last]) begin
                    res.status = STATUS_ORDER;
                end else if (tm_segs >= MAP_DEPTH) begin
                    // order is judged before fullness
                    res.status = STATUS_FULL;
                end else begin
                    tm_tick[tm_segs]   = ev.tick;
                    tm_tempo[tm_segs]  = ev.tempo_us;
                    tm_offset[tm_segs] = pos_add_sat(tm_offset[last],
                        tick_span(ev.tick - tm_tick[last], tm_tempo[last]));
                    tm_segs++;
                end
            end
            KIND_CONVERT: begin
                // last segment starting at or before the tick; equal starts pick the later
                sel      = 0;
                scanning = 1'b1;
                for (i = 1; i < tm_segs; i++) begin
                    if (scanning && tm_tick[i] <= ev.tick)
                        sel = i;
                    else
                        scanning = 1'b0;
                end
                res.sample_pos = pos_add_sat(tm_offset[sel],
                    tick_span(ev.tick - tm_tick[sel], tm_tempo[sel]));
            end
            default: ;
        endcase
        status_tally[res.status]++;
    endtask

    // ---------------------------------------------------------------------------------
    // stimulus helpers
    // ---------------------------------------------------------------------------------

    task automatic queue_item(input logic [KIND_W-1:0] k, input logic [TICK_W-1:0] t,
                              input logic [TEMPO_W-1:0] tp);
        tempo_event_t ev;
        ev.kind     = k;
        ev.tick     = t;
        ev.tempo_us = tp;
        tempo_events.insert(tempo_events.size(), ev);
        // keep the generator's guess of the map in step
        if (k == KIND_CLEAR) begin
            gen_segs     = 1;
            gen_ticks[0] = '0;
        end else if (k == KIND_ADD && t != '0 && t >= gen_ticks[gen_segs-1]
                     && gen_segs < MAP_DEPTH) begin
            gen_ticks[gen_segs] = t;
            gen_segs++;
        end
    endtask

    function automatic logic [TEMPO_W-1:0] pick_tempo();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return TEMPO_W'($urandom_range(200000, 1500000));
        if (r < 72) return TEMPO_W'($urandom_range(1, 24'hFFFFFF));
        if (r < 82) return 24'hFFFFFF;
        if (r < 96) return TEMPO_W'($urandom_range(1, 1000));
        return '0;
    endfunction

    // in-order tick for a tempo change, clamped at the top of the tick range
    function automatic logic [TICK_W-1:0] pick_add_tick(input int reach);
        logic [TICK_W:0]   sum;
        logic [TICK_W-1:0] last;
        int                r;
        last = gen_ticks[gen_segs-1];
        r    = $urandom_range(0, reach);
        if (r < 10)      sum = last;
        else if (r < 50) sum = last + $urandom_range(1, 2000);
        else if (r < 75) sum = last + $urandom_range(1, 1000000);
        else if (r < 90) sum = last + $urandom_range(1, 24'hFFFFFF);
        else             sum = $urandom_range(last, 32'hFFFFFFFF);
        if (sum[TICK_W])
            sum = {1'b0, {TICK_W{1'b1}}};
        return sum[TICK_W-1:0];
    endfunction

    // conversion tick: on, near, between or past the segments, or anywhere
    function automatic logic [TICK_W-1:0] pick_convert_tick();
        int                r;
        int                idx;
        logic [TICK_W-1:0] last;
        last = gen_ticks[gen_segs-1];
        idx  = $urandom_range(0, gen_segs - 1);
        r    = $urandom_range(0, 99);
        if (r < 25) return gen_ticks[idx];
        if (r < 45) return gen_ticks[idx] + $urandom_range(0, 3);
        if (r < 65) return last + $urandom_range(0, 100000);
        if (r < 85) return $urandom();
        return $urandom_range(0, last);
    endfunction

    task automatic queue_broken_add();
        if (gen_segs > 1 && $urandom_range(0, 2) == 0)
            queue_item(KIND_ADD, '0, pick_tempo());
        else if (gen_ticks[gen_segs-1] != '0)
            queue_item(KIND_ADD, $urandom_range(0, gen_ticks[gen_segs-1] - 1), pick_tempo());
        else
            queue_item(KIND_ADD, '0, pick_tempo());
    endtask

    // clear, fill the map to the brim with conversions mixed in, then push past full
    task automatic fill_burst(output int made);
        int n;
        made = 0;
        queue_item(KIND_CLEAR, $urandom(), TEMPO_W'($urandom()));
        made++;
        if ($urandom_range(0, 1) == 0) begin
            queue_item(KIND_ADD, '0, pick_tempo());
            made++;
        end
        while (gen_segs < MAP_DEPTH) begin
            queue_item(KIND_ADD, pick_add_tick(60), pick_tempo());
            made++;
            if ($urandom_range(0, 2) == 0) begin
                queue_item(KIND_CONVERT, pick_convert_tick(), TEMPO_W'($urandom()));
                made++;
            end
        end
        // full map: in order gets full, out of order still gets order
        queue_item(KIND_ADD, pick_add_tick(99), pick_tempo());
        queue_broken_add();
        queue_item(KIND_ADD, gen_ticks[gen_segs-1], pick_tempo());
        made += 3;
        for (n = 0; n < 5; n++)
            queue_item(KIND_CONVERT, pick_convert_tick(), TEMPO_W'($urandom()));
        made += 5;
    endtask

    // a well-filled map to open each phase, then a mix weighted toward in-order changes and rare refills
    task automatic random_items(input int count);
        int made;
        int burst_made;
        int r;
        fill_burst(made);
        while (made < count) begin
            r = $urandom_range(0, 199);
            if (r < 2) begin
                fill_burst(burst_made);
                made += burst_made;
            end else begin
                if (r < 14)
                    queue_item(KIND_CLEAR, $urandom(), TEMPO_W'($urandom()));
                else if (r < 100)
                    queue_item(KIND_ADD, pick_add_tick(99), pick_tempo());
                else if (r < 112)
                    queue_broken_add();
                else if (r < 117)
                    queue_item(KIND_UNUSED, $urandom(), TEMPO_W'($urandom()));
                else
                    queue_item(KIND_CONVERT, pick_convert_tick(), TEMPO_W'($urandom()));
                made++;
            end
        end
    endtask

    // register write over the config channel; only called with the block idle
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        @(posedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        cfg_ch.valid <= 1'b0;
        if (idx == CFG_SAMPLE_RATE)
            rate_cfg = val[RATE_W-1:0];
        else
            div_cfg = val[DIV_W-1:0];
        cfg_writes++;
    endtask

    // returns at a clock edge with nothing queued, offered or owed
    task automatic wait_idle();
        @(posedge clk);
        while (tempo_events.size() != 0 || item_held || due_positions.size() != 0)
            @(posedge clk);
    endtask

    // ---------------------------------------------------------------------------------
    // driver: offers queued items, predicts each one at its handshake
    // ---------------------------------------------------------------------------------
    always @(posedge clk) begin
        if (!rst_n) begin
            req_ch.valid <= 1'b0;
            item_held     = 1'b0;
            send_gap      = 0;
        end else begin
            if (item_held && req_ch.ready) begin
                map_apply(held_ev, predicted_pos);
                due_positions.insert(due_positions.size(), predicted_pos);
                accepted_items++;
                item_held = 1'b0;
            end
            if (!item_held) begin
                if (send_gap > 0) begin
                    send_gap--;
                    req_ch.valid <= 1'b0;
                end else if (tempo_events.size() != 0) begin
                    held_ev   = tempo_events.pop_front();
                    item_held = 1'b1;
                    req_ch.valid    <= 1'b1;
                    req_ch.kind     <= held_ev.kind;
                    req_ch.tick     <= held_ev.tick;
                    req_ch.tempo_us <= held_ev.tempo_us;
                    // the gap is taken after this item is accepted
                    send_gap = (quiet_mode || eager_send) ? 0 : idle_len();
                end else begin
                    req_ch.valid <= 1'b0;
                end
            end
        end
    end

    // long receiver hold-off, counted here and requested by the stimulus
    always @(posedge clk) begin
        if (!rst_n) begin
            hold_left  <= 0;
            holds_done <= 0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end else if (holds_done != holds_asked) begin
            hold_left  <= LONG_HOLD;
            holds_done <= holds_done + 1;
        end
    end

    // ---------------------------------------------------------------------------------
    // monitor: checks each result against the oldest owed position, drives ready
    // ---------------------------------------------------------------------------------
    always @(posedge clk) begin
        if (!rst_n) begin
            rsp_ch.ready <= 1'b0;
            stall_left    = 0;
        end else begin
            if (rsp_ch.valid && rsp_ch.ready) begin
                got_pos.sample_pos = rsp_ch.sample_pos;
                got_pos.status     = rsp_ch.status;
                if (due_positions.size() == 0) begin
                    report_mismatch($sformatf("result with no item outstanding: pos %0h status %0d",
                                              got_pos.sample_pos, got_pos.status));
                end else begin
                    want_pos = due_positions.pop_front();
                    checked_items++;
                    if (got_pos.sample_pos !== want_pos.sample_pos)
                        report_mismatch($sformatf("sample_pos %0h, expected %0h (result %0d)",
                                                  got_pos.sample_pos, want_pos.sample_pos,
                                                  checked_items));
                    if (got_pos.status !== want_pos.status)
                        report_mismatch($sformatf("status %0d, expected %0d (result %0d)",
                                                  got_pos.status, want_pos.status,
                                                  checked_items));
                end
            end
            // ready for the next edge: hold-off first, then random stalls
            if (hold_left != 0 || holds_done != holds_asked) begin
                rsp_ch.ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                rsp_ch.ready <= 1'b0;
            end else if (quiet_mode) begin
                rsp_ch.ready <= 1'b1;
            end else begin
                stall_left = idle_len();
                rsp_ch.ready <= (stall_left == 0);
                if (stall_left > 0)
                    stall_left--;
            end
        end
    end

    // cycle counter and watchdog
    always @(posedge clk)
        cycle_count <= cycle_count + 1;

    initial begin : watchdog
        wait (cycle_count >= CYCLE_LIMIT);
        $display("timeout after %0d cycles, %0d results still owed", cycle_count,
                 due_positions.size());
        $display("end of test: mismatches");
        $finish;
    end

    // ---------------------------------------------------------------------------------
    // stimulus: phases of settings, each run until the block is idle again
    // ---------------------------------------------------------------------------------
    initial begin : stimulus
        logic [CFG_DATA_W-1:0] cfg_val;

        // config channel idle from time zero; driver and monitor clear the rest in reset
        rst_n            = 1'b0;
        cfg_ch.valid     = 1'b0;
        cfg_ch.index     = CFG_SAMPLE_RATE;
        cfg_ch.data      = '0;
        status_tally     = '{default: 0};

        // shadow map and registers as after reset
        tm_segs      = 1;
        tm_tick[0]   = '0;
        tm_tempo[0]  = DEFAULT_TEMPO;
        tm_offset[0] = '0;
        rate_cfg     = RESET_RATE;
        div_cfg      = RESET_DIV;
        gen_segs     = 1;
        gen_ticks[0] = '0;

        repeat (3) @(negedge clk);
        rst_n = 1'b1;

        // reset settings: edges of the tick range, tick-zero tempo rewrite,
        // order rules, equal ticks, unused kind, clear
        queue_item(KIND_CONVERT, 32'd0, 24'd0);
        queue_item(KIND_CONVERT, 32'hFFFFFFFF, 24'hFFFFFF);
        queue_item(KIND_UNUSED, 32'hFFFFFFFF, 24'hFFFFFF);
        queue_item(KIND_ADD, 32'd0, 24'd1);
        queue_item(KIND_CONVERT, 32'd480000, 24'd0);
        queue_item(KIND_ADD, 32'd0, 24'hFFFFFF);
        queue_item(KIND_ADD, 32'd1000, 24'd500000);
        queue_item(KIND_ADD, 32'd0, 24'd250000);
        queue_item(KIND_ADD, 32'd999, 24'd250000);
        queue_item(KIND_ADD, 32'd1000, 24'd300000);
        queue_item(KIND_CONVERT, 32'd1000, 24'd0);
        queue_item(KIND_CONVERT, 32'd999, 24'd0);
        queue_item(KIND_CLEAR, 32'hFFFFFFFF, 24'hFFFFFF);
        queue_item(KIND_CONVERT, 32'd480, 24'd0);
        random_items(PHASE_ITEMS);
        wait_idle();

        // top rate, division one: spans and offsets run into saturation
        write_reg(CFG_SAMPLE_RATE, 18'd192000);
        write_reg(CFG_DIVISION, 18'd1);
        queue_item(KIND_CLEAR, 32'd0, 24'd0);
        queue_item(KIND_ADD, 32'd0, 24'hFFFFFF);
        queue_item(KIND_ADD, 32'd1000, 24'hFFFFFF);
        queue_item(KIND_ADD, 32'd2000, 24'd1);
        queue_item(KIND_CONVERT, 32'd999, 24'd0);
        queue_item(KIND_CONVERT, 32'd1500, 24'd0);
        queue_item(KIND_CONVERT, 32'd2000, 24'd0);
        queue_item(KIND_ADD, 32'd2100, 24'd0);
        queue_item(KIND_CONVERT, 32'd2200, 24'd0);
        queue_item(KIND_CONVERT, 32'hFFFFFFFF, 24'd0);
        random_items(PHASE_ITEMS);
        wait_idle();

        // lowest rate, largest division, no idling on either side
        write_reg(CFG_SAMPLE_RATE, 18'd1);
        write_reg(CFG_DIVISION, 18'd32767);
        quiet_mode <= 1'b1;
        random_items(PHASE_ITEMS);
        wait_idle();
        quiet_mode <= 1'b0;

        // zero division register, treated as one
        write_reg(CFG_SAMPLE_RATE, 18'd48000);
        write_reg(CFG_DIVISION, 18'd0);
        random_items(PHASE_ITEMS);
        wait_idle();

        // random settings; sender never pauses while the receiver holds off,
        // so the block fills up and stalls its input
        cfg_val = CFG_DATA_W'($urandom_range(1, 192000));
        write_reg(CFG_SAMPLE_RATE, cfg_val);
        cfg_val = CFG_DATA_W'($urandom_range(1, 32767));
        write_reg(CFG_DIVISION, cfg_val);
        eager_send  <= 1'b1;
        holds_asked <= holds_asked + 1;
        random_items(PHASE_ITEMS);
        wait_idle();
        eager_send <= 1'b0;

        // let any stray result show up before closing
        repeat (SETTLE) @(posedge clk);
        if (due_positions.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", due_positions.size()));

        $display("covered %0d items over %0d register writes, %0d results checked",
                 accepted_items, cfg_writes, checked_items);
        $display("statuses seen: %0d ok, %0d map full, %0d out of order",
                 status_tally[STATUS_OK], status_tally[STATUS_FULL],
                 status_tally[STATUS_ORDER]);
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

[filelist.f]
sv/tmts_pkg.sv
sv/tmts_req_if.sv
sv/tmts_rsp_if.sv
sv/tmts_cfg_if.sv
sv/tmts_ram.sv
sv/tmts_span.sv
sv/tempo_map_tick_to_sample_core.sv
verif/tempo_map_tick_to_sample_core_test.sv
